// File: sv/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: sv/gda_pkg.sv
// types, constants and calendar helpers for the date arithmetic block
`default_nettype none

package gda_pkg;

  typedef logic [4:0]  day_t;
  typedef logic [3:0]  mon_t;
  typedef logic [13:0] year_t;

  localparam year_t MAX_YEAR = 14'd9999;
  localparam mon_t  LAST_MONTH = 4'd12;
  localparam day_t  LAST_DAY_DEC = 5'd31;
  localparam day_t  FEB_DAYS = 5'd28;
  localparam day_t  FEB_LEAP_DAYS = 5'd29;
  // ceil(2^17 / 25), exact quotient for every 14-bit year
  localparam logic [12:0] DIV25_RECIP = 13'd5243;

  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_SUB  = 2'd1;
  localparam logic [1:0] MODE_DIFF = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_LATER = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_NORM_MAIN,
    OP_NORM_OTH,
    OP_INC_MAIN,
    OP_DEC_MAIN,
    OP_INC_OTH,
    OP_CLR_CNT,
    OP_SET_RANGE,
    OP_SET_LATER,
    OP_SET_SAT,
    OP_FINISH
  } op_t;

  typedef struct packed {
    logic range;
    logic mode_add;
    logic mode_sub;
    logic mode_diff;
    logic cnt_zero;
    logic cnt_max;
    logic at_last;
    logic at_first;
    logic oy_bad;
    logic oth_later;
    logic dates_eq;
  } flags_t;

  // y%4==0 and (y%25!=0 or y%16==0), quotient by 25 via reciprocal
  function automatic logic is_leap(year_t y);
    logic [26:0] prod;
    logic [9:0]  q;
    year_t       q25;
    prod = 27'(y) * 27'(DIV25_RECIP);
    q    = prod[26:17];
    q25  = 14'(q) * 14'd25;
    return (y[1:0] == 2'b00) && ((q25 != y) || (y[3:0] == 4'b0000));
  endfunction

  function automatic day_t month_days(mon_t m, logic leap);
    unique case (m)
      4'd2:                     return leap ? FEB_LEAP_DAYS : FEB_DAYS;
      4'd4, 4'd6, 4'd9, 4'd11:  return 5'd30;
      default:                  return 5'd31;
    endcase
  endfunction

  function automatic mon_t clamp_month(mon_t m);
    if (m == 4'd0) return 4'd1;
    if (m > LAST_MONTH) return LAST_MONTH;
    return m;
  endfunction

  function automatic day_t clamp_day(day_t d, day_t len);
    if (d == 5'd0) return 5'd1;
    if (d > len) return len;
    return d;
  endfunction

endpackage

`default_nettype wire

// File: sv/gda_seq.sv
// microcode sequencer: control store, step counter and jump logic
`default_nettype none

module gda_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  gda_pkg::flags_t flags,
  output gda_pkg::op_t    op,
  output logic            busy
);
  import gda_pkg::*;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_RANGE,
    C_MODE_ADD,
    C_MODE_SUB,
    C_MODE_DIFF,
    C_CNT_ZERO,
    C_ADD_EXIT,
    C_SUB_EXIT,
    C_OY_BAD,
    C_OTH_LATER,
    C_DIFF_EXIT,
    C_DATES_EQ
  } cond_t;

  // gated: the step's op is dropped when the jump is taken
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  gated;
    pc_t   nt;
    pc_t   nf;
  } uword_t;

  localparam pc_t P_NORM  = 5'd0;
  localparam pc_t P_CHK   = 5'd1;
  localparam pc_t P_D0    = 5'd2;
  localparam pc_t P_D1    = 5'd3;
  localparam pc_t P_D2    = 5'd4;
  localparam pc_t P_ADD   = 5'd5;
  localparam pc_t P_ADDX  = 5'd6;
  localparam pc_t P_SUB   = 5'd7;
  localparam pc_t P_SUBX  = 5'd8;
  localparam pc_t P_OVF   = 5'd9;
  localparam pc_t P_DIFF  = 5'd10;
  localparam pc_t P_DCMP  = 5'd11;
  localparam pc_t P_DLOOP = 5'd12;
  localparam pc_t P_DX    = 5'd13;
  localparam pc_t P_SATST = 5'd14;
  localparam pc_t P_LATER = 5'd15;
  localparam pc_t P_FIN   = 5'd16;

  function automatic uword_t ucode(pc_t a);
    unique case (a)
      P_NORM:  return '{OP_NORM_MAIN, C_ALWAYS,    1'b0, P_CHK,   P_CHK};
      P_CHK:   return '{OP_NOP,       C_RANGE,     1'b0, P_FIN,   P_D0};
      P_D0:    return '{OP_NOP,       C_MODE_ADD,  1'b0, P_ADD,   P_D1};
      P_D1:    return '{OP_NOP,       C_MODE_SUB,  1'b0, P_SUB,   P_D2};
      P_D2:    return '{OP_NOP,       C_MODE_DIFF, 1'b0, P_DIFF,  P_FIN};
      P_ADD:   return '{OP_INC_MAIN,  C_ADD_EXIT,  1'b1, P_ADDX,  P_ADD};
      P_ADDX:  return '{OP_NOP,       C_CNT_ZERO,  1'b0, P_FIN,   P_OVF};
      P_SUB:   return '{OP_DEC_MAIN,  C_SUB_EXIT,  1'b1, P_SUBX,  P_SUB};
      P_SUBX:  return '{OP_NOP,       C_CNT_ZERO,  1'b0, P_FIN,   P_OVF};
      P_OVF:   return '{OP_SET_RANGE, C_ALWAYS,    1'b0, P_FIN,   P_FIN};
      P_DIFF:  return '{OP_NORM_OTH,  C_OY_BAD,    1'b1, P_OVF,   P_DCMP};
      P_DCMP:  return '{OP_CLR_CNT,   C_OTH_LATER, 1'b0, P_LATER, P_DLOOP};
      P_DLOOP: return '{OP_INC_OTH,   C_DIFF_EXIT, 1'b1, P_DX,    P_DLOOP};
      P_DX:    return '{OP_NOP,       C_DATES_EQ,  1'b0, P_FIN,   P_SATST};
      P_SATST: return '{OP_SET_SAT,   C_ALWAYS,    1'b0, P_FIN,   P_FIN};
      P_LATER: return '{OP_SET_LATER, C_ALWAYS,    1'b0, P_FIN,   P_FIN};
      default: return '{OP_FINISH,    C_ALWAYS,    1'b0, P_FIN,   P_FIN};
    endcase
  endfunction

  pc_t    pc;
  uword_t word;
  logic   take;

  assign word = ucode(pc);

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:    take = 1'b1;
      C_RANGE:     take = flags.range;
      C_MODE_ADD:  take = flags.mode_add;
      C_MODE_SUB:  take = flags.mode_sub;
      C_MODE_DIFF: take = flags.mode_diff;
      C_CNT_ZERO:  take = flags.cnt_zero;
      C_ADD_EXIT:  take = flags.cnt_zero | flags.at_last;
      C_SUB_EXIT:  take = flags.cnt_zero | flags.at_first;
      C_OY_BAD:    take = flags.oy_bad;
      C_OTH_LATER: take = flags.oth_later;
      C_DIFF_EXIT: take = flags.dates_eq | flags.cnt_max;
      C_DATES_EQ:  take = flags.dates_eq;
      default:     take = 1'b1;
    endcase
  end

  assign op = !busy ? OP_NOP : ((word.gated && take) ? OP_NOP : word.op);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= P_NORM;
    end else if (accept) begin
      busy <= 1'b1;
      pc   <= P_NORM;
    end else if (busy) begin
      pc <= take ? word.nt : word.nf;
      if (word.op == OP_FINISH) busy <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: sv/gda_dp.sv
// datapath: date registers, day stepper, day counter and result registers
`default_nettype none

module gda_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  gda_pkg::op_t      op,
  input  logic [1:0]        mode,
  input  logic [4:0]        day,
  input  logic [3:0]        month,
  input  logic [13:0]       year,
  input  logic [15:0]       day_count,
  input  logic [4:0]        other_day,
  input  logic [3:0]        other_month,
  input  logic [13:0]       other_year,
  output gda_pkg::flags_t   flags,
  output logic              done,
  output logic [4:0]        res_day,
  output logic [3:0]        res_month,
  output logic [13:0]       res_year,
  output logic [15:0]       days_between,
  output logic [1:0]        status
);
  import gda_pkg::*;

  logic [1:0]             mode_r;
  day_t                   cd, od;
  mon_t                   cm, om;
  year_t                  cy, oy;
  logic [COUNT_WIDTH-1:0] cnt;
  status_t                st;

  // main date: normalize and step
  year_t ys;
  logic  m_leap;
  mon_t  ms;
  day_t  ds, len_norm, len_cur, len_prev;

  assign ys       = (cy > MAX_YEAR) ? MAX_YEAR : cy;
  assign m_leap   = is_leap(ys);
  assign ms       = clamp_month(cm);
  assign len_norm = month_days(ms, m_leap);
  assign ds       = clamp_day(cd, len_norm);
  assign len_cur  = month_days(cm, m_leap);
  assign len_prev = month_days(4'(cm - 4'd1), m_leap);

  // second date: normalize and step
  logic o_leap;
  mon_t oms;
  day_t ods, olen_norm, olen_cur;

  assign o_leap    = is_leap(oy);
  assign oms       = clamp_month(om);
  assign olen_norm = month_days(oms, o_leap);
  assign ods       = clamp_day(od, olen_norm);
  assign olen_cur  = month_days(om, o_leap);

  always_comb begin
    flags.range     = (st == ST_RANGE);
    flags.mode_add  = (mode_r == MODE_ADD);
    flags.mode_sub  = (mode_r == MODE_SUB);
    flags.mode_diff = (mode_r == MODE_DIFF);
    flags.cnt_zero  = (cnt == '0);
    flags.cnt_max   = (cnt == '1);
    flags.at_last   = (cy == MAX_YEAR) && (cm == LAST_MONTH) && (cd == LAST_DAY_DEC);
    flags.at_first  = (cy == '0) && (cm == 4'd1) && (cd == 5'd1);
    flags.oy_bad    = (oy > MAX_YEAR);
    flags.oth_later = (oy > cy) || ((oy == cy) && (om > cm)) ||
                      ((oy == cy) && (om == cm) && (od > cd));
    flags.dates_eq  = (oy == cy) && (om == cm) && (od == cd);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= mode;
      cd     <= day;
      cm     <= month;
      cy     <= year;
      od     <= other_day;
      om     <= other_month;
      oy     <= other_year;
      cnt    <= COUNT_WIDTH'(day_count);
      st     <= ST_OK;
    end else begin
      case (op)
        OP_NORM_MAIN: begin
          cy <= ys;
          cm <= ms;
          cd <= ds;
          st <= (cy > MAX_YEAR) ? ST_RANGE : ST_OK;
        end
        OP_NORM_OTH: begin
          om <= oms;
          od <= ods;
        end
        OP_INC_MAIN: begin
          cnt <= cnt - COUNT_WIDTH'(1);
          if (cd < len_cur) begin
            cd <= cd + 5'd1;
          end else if (cm < LAST_MONTH) begin
            cd <= 5'd1;
            cm <= cm + 4'd1;
          end else begin
            cd <= 5'd1;
            cm <= 4'd1;
            cy <= cy + 14'd1;
          end
        end
        OP_DEC_MAIN: begin
          cnt <= cnt - COUNT_WIDTH'(1);
          if (cd > 5'd1) begin
            cd <= cd - 5'd1;
          end else if (cm > 4'd1) begin
            cm <= cm - 4'd1;
            cd <= len_prev;
          end else begin
            cm <= LAST_MONTH;
            cd <= LAST_DAY_DEC;
            cy <= cy - 14'd1;
          end
        end
        OP_INC_OTH: begin
          cnt <= cnt + COUNT_WIDTH'(1);
          if (od < olen_cur) begin
            od <= od + 5'd1;
          end else if (om < LAST_MONTH) begin
            od <= 5'd1;
            om <= om + 4'd1;
          end else begin
            od <= 5'd1;
            om <= 4'd1;
            oy <= oy + 14'd1;
          end
        end
        OP_CLR_CNT:   cnt <= '0;
        OP_SET_RANGE: st <= ST_RANGE;
        OP_SET_LATER: st <= ST_LATER;
        OP_SET_SAT:   st <= ST_SAT;
        default: ;
      endcase
    end
  end

  // result registers, strobed for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (op == OP_FINISH);
    end
    if (op == OP_FINISH) begin
      res_day   <= cd;
      res_month <= cm;
      res_year  <= cy;
      status    <= st;
      // counter holds the difference only on a clean or saturated difference
      days_between <= ((mode_r == MODE_DIFF) && ((st == ST_OK) || (st == ST_SAT)))
                      ? 16'(cnt) : 16'd0;
    end
  end

endmodule

`default_nettype wire

// File: sv/gregorian_date_arithmetic.sv
// top level of the gregorian date add, subtract and difference block
//
//  channel   handshake             payload
//  input     start / busy          mode day month year day_count other_*
//  result    done (one cycle)      res_day res_month res_year days_between status
//
// busy stays high while a command runs: add and subtract step until the count
// runs out or the date reaches a calendar limit, a difference until the dates
// meet or the day counter saturates; the datapath steps one calendar day per
// cycle under the microcode loop step.
// busy rises at the edge that takes the transaction and falls as done rises.
// rst is synchronous; it clears the step counter, busy and done.
// the receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module gregorian_date_arithmetic #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  input  logic [15:0] day_count,
  input  logic [4:0]  other_day,
  input  logic [3:0]  other_month,
  input  logic [13:0] other_year,
  output logic        done,
  output logic [4:0]  res_day,
  output logic [3:0]  res_month,
  output logic [13:0] res_year,
  output logic [15:0] days_between,
  output logic [1:0]  status
);
  import gda_pkg::*;

  logic   accept;
  op_t    op;
  flags_t flags;

  assign accept = start & ~busy;

  gda_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .flags  (flags),
    .op     (op),
    .busy   (busy)
  );

  gda_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .op           (op),
    .mode         (mode),
    .day          (day),
    .month        (month),
    .year         (year),
    .day_count    (day_count),
    .other_day    (other_day),
    .other_month  (other_month),
    .other_year   (other_year),
    .flags        (flags),
    .done         (done),
    .res_day      (res_day),
    .res_month    (res_month),
    .res_year     (res_year),
    .days_between (days_between),
    .status       (status)
  );

endmodule

`default_nettype wire

// File: sv/gda_chk.sv
// port-level checker for the date arithmetic block, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module gda_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [3:0]  res_month,
  input logic [4:0]  res_day,
  input logic [15:0] days_between,
  input logic [1:0]  status
);
  import gda_pkg::*;

  // a result ends the transaction that was in flight
  `ASSERT_IMP(a_done_ends_busy, done, $past(busy) && !busy)
  `ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `ASSERT_NXT(a_done_single, done, !done)
  // a day count only comes with a clean or saturated difference
  `ASSERT_IMP(a_between_status, done && (days_between != 16'd0),
              (status == ST_OK) || (status == ST_SAT))
  `ASSERT_IMP(a_date_legal, done,
              (res_month >= 4'd1) && (res_month <= 4'd12) && (res_day >= 5'd1))

endmodule

bind gregorian_date_arithmetic gda_chk u_chk (.*);

`default_nettype wire

// File: sim/tb.sv
// testbench for gregorian_date_arithmetic: directed and random date commands checked against a predictor
`default_nettype none

module tb;
  import gda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned COUNT_MAX = 32'd65535;

  typedef struct packed {
    logic [1:0]  mode;
    day_t        day;
    mon_t        month;
    year_t       year;
    logic [15:0] day_count;
    day_t        other_day;
    mon_t        other_month;
    year_t       other_year;
  } date_cmd_t;

  typedef struct packed {
    day_t        res_day;
    mon_t        res_month;
    year_t       res_year;
    logic [15:0] days_between;
    status_t     status;
  } date_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [15:0] day_count;
  logic [4:0]  other_day;
  logic [3:0]  other_month;
  logic [13:0] other_year;
  logic        done;
  logic [4:0]  res_day;
  logic [3:0]  res_month;
  logic [13:0] res_year;
  logic [15:0] days_between;
  logic [1:0]  status;

  date_result_t pending_dates[$];
  int          errors = 0;
  longint      cycles = 0;
  longint      cycle_budget = 20000;
  int          burst_left = 0;

  gregorian_date_arithmetic DUT (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // calendar arithmetic on serial day numbers counted from 0000-01-01

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned days_of_month(int unsigned m, int unsigned y);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int unsigned year_first_day(int unsigned y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic int unsigned serial_of(int unsigned d, int unsigned m, int unsigned y);
    int unsigned s;
    s = year_first_day(y);
    for (int unsigned k = 1; k < m; k++) s += days_of_month(k, y);
    return s + d - 1;
  endfunction

  function automatic void date_of_serial(input int unsigned s, output int unsigned d,
                                         output int unsigned m, output int unsigned y);
    int unsigned yy;
    int unsigned mm;
    int unsigned rem;
    yy = int'((64'(s) * 64'd400) / 64'd146097);
    while (year_first_day(yy + 1) <= s) yy++;
    while (yy > 0 && year_first_day(yy) > s) yy--;
    rem = s - year_first_day(yy);
    mm = 1;
    while (mm < 12 && rem >= days_of_month(mm, yy)) begin
      rem -= days_of_month(mm, yy);
      mm++;
    end
    d = rem + 1;
    m = mm;
    y = yy;
  endfunction

  function automatic void clamp_date(inout int unsigned d, inout int unsigned m,
                                     input int unsigned y);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > days_of_month(m, y)) d = days_of_month(m, y);
  endfunction

  function automatic date_result_t predict_date(date_cmd_t c);
    int unsigned d, m, y, od, om, oy, cnt;
    int unsigned rd, rm, ry, s, os, last, between;
    status_t st;
    date_result_t r;
    d = 32'(c.day);
    m = 32'(c.month);
    y = 32'(c.year);
    od = 32'(c.other_day);
    om = 32'(c.other_month);
    oy = 32'(c.other_year);
    cnt = 32'(c.day_count);
    between = 0;
    st = ST_OK;
    if (y > MAX_YEAR) begin
      y = 32'(MAX_YEAR);
      st = ST_RANGE;
    end
    clamp_date(d, m, y);
    rd = d;
    rm = m;
    ry = y;
    if (st == ST_OK) begin
      s = serial_of(d, m, y);
      last = serial_of(31, 12, 32'(MAX_YEAR));
      case (c.mode)
        MODE_ADD: begin
          if (s + cnt > last) begin
            s = last;
            st = ST_RANGE;
          end else begin
            s += cnt;
          end
          date_of_serial(s, rd, rm, ry);
        end
        MODE_SUB: begin
          if (cnt > s) begin
            s = 0;
            st = ST_RANGE;
          end else begin
            s -= cnt;
          end
          date_of_serial(s, rd, rm, ry);
        end
        MODE_DIFF: begin
          if (oy > MAX_YEAR) begin
            st = ST_RANGE;
          end else begin
            clamp_date(od, om, oy);
            os = serial_of(od, om, oy);
            if (os > s) begin
              st = ST_LATER;
            end else if (s - os > COUNT_MAX) begin
              between = COUNT_MAX;
              st = ST_SAT;
            end else begin
              between = s - os;
            end
          end
        end
        default: ;
      endcase
    end
    r.res_day = rd[4:0];
    r.res_month = rm[3:0];
    r.res_year = ry[13:0];
    r.days_between = between[15:0];
    r.status = st;
    return r;
  endfunction

  // one transaction: hold start until the block takes it, then maybe idle a while
  task automatic send_cmd(input logic [1:0] md, input day_t d, input mon_t m, input year_t y,
                          input logic [15:0] cnt, input day_t od, input mon_t om,
                          input year_t oy);
    date_cmd_t c;
    date_result_t r;
    int gap;
    c = '{md, d, m, y, cnt, od, om, oy};
    @(negedge clk);
    mode = md;
    day = d;
    month = m;
    year = y;
    day_count = cnt;
    other_day = od;
    other_month = om;
    other_year = oy;
    start = 1'b1;
    do @(posedge clk); while (busy);
    r = predict_date(c);
    pending_dates.push_back(r);
    if (md == MODE_DIFF) cycle_budget += (r.status == ST_OK ? r.days_between : 65536) + 16;
    else cycle_budget += cnt + 16;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(1, 20);
      @(negedge clk) start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    @(negedge clk) start = 1'b0;
    while (pending_dates.size() != 0) @(negedge clk);
  endtask

  task automatic test_add_days();
    send_cmd(MODE_ADD, 5'd1, 4'd1, 14'd0, 16'd0, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd28, 4'd2, 14'd2000, 16'd1, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd28, 4'd2, 14'd1900, 16'd1, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd31, 4'd12, 14'd2024, 16'd1, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd1, 4'd1, 14'd2000, 16'hFFFF, 5'd0, 4'd0, 14'd0);
    // past the last representable day
    send_cmd(MODE_ADD, 5'd31, 4'd12, 14'd9999, 16'd1, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd1, 4'd6, 14'd9999, 16'hFFFF, 5'd0, 4'd0, 14'd0);
  endtask

  task automatic test_subtract_days();
    send_cmd(MODE_SUB, 5'd1, 4'd1, 14'd0, 16'd1, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_SUB, 5'd1, 4'd3, 14'd2000, 16'd1, 5'd0, 4'd0, 14'd0);
    // year zero is a leap year
    send_cmd(MODE_SUB, 5'd1, 4'd1, 14'd1, 16'd366, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_SUB, 5'd31, 4'd12, 14'd9999, 16'hFFFF, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_SUB, 5'd15, 4'd8, 14'd1999, 16'd0, 5'd0, 4'd0, 14'd0);
  endtask

  task automatic test_difference();
    send_cmd(MODE_DIFF, 5'd1, 4'd1, 14'd2000, 16'd0, 5'd1, 4'd1, 14'd2000);
    send_cmd(MODE_DIFF, 5'd1, 4'd3, 14'd2000, 16'd0, 5'd28, 4'd2, 14'd2000);
    send_cmd(MODE_DIFF, 5'd1, 4'd1, 14'd2000, 16'd0, 5'd2, 4'd1, 14'd2000);
    // let the block go idle before the longest transaction
    drain_results();
    send_cmd(MODE_DIFF, 5'd31, 4'd12, 14'd9999, 16'd0, 5'd1, 4'd1, 14'd0);
    send_cmd(MODE_DIFF, 5'd10, 4'd5, 14'd2010, 16'd0, 5'd0, 4'd0, 14'd2009);
    send_cmd(MODE_DIFF, 5'd10, 4'd5, 14'd2010, 16'd0, 5'd31, 4'd15, 14'd16383);
  endtask

  task automatic test_normalization();
    send_cmd(MODE_ADD, 5'd0, 4'd0, 14'd2001, 16'd0, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd31, 4'd15, 14'd2001, 16'd0, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd31, 4'd2, 14'd2004, 16'd0, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd31, 4'd2, 14'd2100, 16'd0, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_ADD, 5'd31, 4'd4, 14'd2003, 16'd0, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_SUB, 5'd5, 4'd5, 14'd16383, 16'd10, 5'd0, 4'd0, 14'd0);
    send_cmd(MODE_DIFF, 5'd31, 4'd2, 14'd12000, 16'd0, 5'd1, 4'd1, 14'd100);
    send_cmd(MODE_UNUSED, 5'd31, 4'd2, 14'd2001, 16'd77, 5'd3, 4'd3, 14'd1999);
  endtask

  function automatic void rand_date(output day_t d, output mon_t m, output year_t y);
    if ($urandom_range(0, 99) < 88) begin
      d = 5'($urandom_range(1, 28));
      m = 4'($urandom_range(1, 12));
      y = 14'($urandom_range(0, 9999));
    end else begin
      d = 5'($urandom_range(0, 31));
      m = 4'($urandom_range(0, 15));
      y = 14'($urandom_range(0, 16383));
    end
  endfunction

  task automatic test_random(input int n_items);
    logic [1:0] md;
    day_t d, od;
    mon_t m, om;
    year_t y, oy;
    logic [15:0] cnt;
    int unsigned nd, nm, s, os, ud, um, uy;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      md = pick < 40 ? MODE_ADD : pick < 70 ? MODE_SUB : pick < 95 ? MODE_DIFF : MODE_UNUSED;
      rand_date(d, m, y);
      rand_date(od, om, oy);
      // keep most counts short so the run stays bounded
      cnt = ($urandom_range(0, 99) < 92) ? 16'($urandom_range(0, 2000))
                                         : 16'($urandom_range(0, 65535));
      if (md == MODE_DIFF && y <= MAX_YEAR && $urandom_range(0, 99) < 85) begin
        nd = 32'(d);
        nm = 32'(m);
        clamp_date(nd, nm, 32'(y));
        s = serial_of(nd, nm, 32'(y));
        if ($urandom_range(0, 99) < 90) begin
          pick = $urandom_range(0, 2000);
          os = (s >= pick) ? s - pick : 0;
        end else begin
          os = s + $urandom_range(1, 50);
        end
        date_of_serial(os, ud, um, uy);
        od = ud[4:0];
        om = um[3:0];
        oy = uy[13:0];
      end
      send_cmd(md, d, m, y, cnt, od, om, oy);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    date_result_t exp_r;
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result with no transaction outstanding", $time);
        errors++;
      end else begin
        exp_r = pending_dates.pop_front();
        compare_field("res_day", 16'(exp_r.res_day), 16'(res_day));
        compare_field("res_month", 16'(exp_r.res_month), 16'(res_month));
        compare_field("res_year", 16'(exp_r.res_year), 16'(res_year));
        compare_field("days_between", exp_r.days_between, days_between);
        compare_field("status", 16'(exp_r.status), 16'(status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3 * cycle_budget + 50000) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    mode = '0;
    day = '0;
    month = '0;
    year = '0;
    day_count = '0;
    other_day = '0;
    other_month = '0;
    other_year = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_add_days();
    test_subtract_days();
    test_difference();
    test_normalization();
    test_random(75);
    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
